### design/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg: shared types and constants of the positional insert/delete array
// Command and status codes, array geometry, and the per-cycle control bundle
// that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int MaxEntries = 16;
  localparam int DataW      = 32;
  localparam int PosW       = 5;
  localparam int LenW       = 5;
  localparam int CmdW       = 3;
  localparam int StatusW    = 2;

  typedef enum logic [CmdW-1:0] {
    CmdRead   = 3'd0,
    CmdWrite  = 3'd1,
    CmdInsert = 3'd2,
    CmdDelete = 3'd3,
    CmdSetLen = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk   = 2'd0,
    StPos  = 2'd1,
    StFull = 2'd2,
    StLen  = 2'd3
  } status_e;

  // What every cell does in the cycle a beat is taken.
  typedef enum logic [2:0] {
    OpHold,
    OpWrite,
    OpInsert,
    OpDelete,
    OpTrim
  } cell_op_e;

  typedef struct packed {
    cell_op_e              op;
    logic [PosW-1:0]       pos;
    logic [LenW-1:0]       nlen;
    logic signed [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

### design/pida_cell.sv
// ----------------------------------------------------------------------------
// pida_cell: one slot of the array
// Holds one word and, on an insert or delete, takes the word of its lower or
// upper neighbor so that the whole row shifts in the same cycle.
// ----------------------------------------------------------------------------
module pida_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [pida_pkg::PosW-1:0]     idx_i,
  input  pida_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [pida_pkg::DataW-1:0] lower_i,
  input  logic signed [pida_pkg::DataW-1:0] upper_i,
  output logic signed [pida_pkg::DataW-1:0] entry_o
);
  import pida_pkg::*;

  logic signed [DataW-1:0] entry_d, entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OpWrite: begin
        if (idx_i == ctrl_i.pos) entry_d = ctrl_i.value;
      end
      OpInsert: begin
        if (idx_i == ctrl_i.pos) begin
          entry_d = ctrl_i.value;
        end else if (idx_i > ctrl_i.pos) begin
          entry_d = lower_i;
        end
      end
      OpDelete: begin
        // Slots past the length are zero, so the top cell pulls in zero.
        if (idx_i >= ctrl_i.pos) entry_d = upper_i;
      end
      OpTrim: begin
        if (idx_i >= PosW'(ctrl_i.nlen)) entry_d = '0;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en_i) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

### design/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array: ordered word array with insert and delete
// Read, write, insert, delete and set-length commands on a row of cells
// that shift in parallel; one result beat per command beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid_i / in_stall_o    cmd, pos, value, new_length
//  out       output     out_valid_o / out_stall_i  read_value, status, length
//
//  All cells update together at the accepting edge and the result beat
//  appears in the output register the cycle after. A new command is taken
//  while the previous result is being taken; only a held result stalls the
//  input. Reset clears every slot and the length.
module positional_insert_delete_array (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pida_pkg::CmdW-1:0]           cmd_i,
  input  logic [pida_pkg::PosW-1:0]           pos_i,
  input  logic signed [pida_pkg::DataW-1:0]   value_i,
  input  logic [pida_pkg::LenW-1:0]           new_length_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pida_pkg::DataW-1:0]   read_value_o,
  output logic [pida_pkg::StatusW-1:0]        status_o,
  output logic [pida_pkg::LenW-1:0]           length_o
);
  import pida_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxEntries);

  logic                    accept;
  logic [LenW-1:0]         len_d, len_q;
  status_e                 status_d;
  logic signed [DataW-1:0] rd_d;
  cell_ctrl_t              ctrl;
  logic signed [DataW-1:0] entries [MaxEntries];

  logic                    out_valid_q;
  logic signed [DataW-1:0] read_value_q;
  status_e                 status_q;
  logic [LenW-1:0]         length_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Word at pos, picked out by an AND-OR over the row.
  logic signed [DataW-1:0] sel_word;
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (pos_i == PosW'(i)) sel_word = sel_word | entries[i];
    end
  end

  always_comb begin
    len_d       = len_q;
    status_d    = StOk;
    rd_d        = '0;
    ctrl.op     = OpHold;
    ctrl.pos    = pos_i;
    ctrl.nlen   = new_length_i;
    ctrl.value  = value_i;
    case (cmd_i)
      CmdRead: begin
        if (PosW'(pos_i) < PosW'(len_q)) rd_d = sel_word;
        else status_d = StPos;
      end
      CmdWrite: begin
        if (pos_i < PosW'(len_q)) ctrl.op = OpWrite;
        else status_d = StPos;
      end
      CmdInsert: begin
        if (pos_i > PosW'(len_q)) begin
          status_d = StPos;
        end else if (len_q >= MaxLen) begin
          status_d = StFull;
        end else begin
          ctrl.op = OpInsert;
          len_d   = len_q + LenW'(1);
        end
      end
      CmdDelete: begin
        if (pos_i < PosW'(len_q)) begin
          ctrl.op = OpDelete;
          len_d   = len_q - LenW'(1);
        end else begin
          status_d = StPos;
        end
      end
      CmdSetLen: begin
        if (new_length_i > MaxLen) begin
          status_d = StLen;
        end else begin
          ctrl.op = OpTrim;
          len_d   = new_length_i;
        end
      end
      default: status_d = StOk;
    endcase
  end

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    logic signed [DataW-1:0] lower, upper;
    if (g == 0) begin : g_lo
      assign lower = '0;
    end else begin : g_lo
      assign lower = entries[g-1];
    end
    if (g == MaxEntries - 1) begin : g_hi
      assign upper = '0;
    end else begin : g_hi
      assign upper = entries[g+1];
    end
    pida_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .idx_i   (PosW'(g)),
      .ctrl_i  (ctrl),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entries[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= rd_d;
      status_q     <= status_d;
      length_q     <= len_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

endmodule
